### hw/rtl/tls_pkg.sv
// ----------------------------------------------------------------------------
// tls_pkg
// Shared types and constants of the two-level tick scheduler.
// ----------------------------------------------------------------------------
package tls_pkg;

	localparam int ID_W        = 4;
	localparam int BURST_W     = 8;
	localparam int TICK_W      = 16;
	localparam int SLICE_W     = 8;
	localparam int ID_SLOTS    = 16;
	localparam int MAX_JOBS_DEF = 16;

	localparam logic [SLICE_W-1:0] QUANTUM_RESET = 8'd4;

	// request encodings on the input item
	localparam logic REQ_TICK   = 1'b1;
	localparam logic CLASS_HIGH = 1'b0;

	// classified command codes
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_ARRIVE_HIGH = 2'd0;
	localparam logic [OP_W-1:0] OP_ARRIVE_LOW  = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK        = 2'd2;

	typedef struct packed {
		logic               req_type;
		logic [ID_W-1:0]    job_id;
		logic               job_class;
		logic [BURST_W-1:0] burst;
	} req_t;

	typedef struct packed {
		logic               running_valid;
		logic [ID_W-1:0]    running_id;
		logic               done_valid;
		logic [ID_W-1:0]    done_id;
		logic [TICK_W-1:0]  turnaround;
		logic [TICK_W-1:0]  waiting;
	} rsp_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
	} cmd_t;

endpackage

### hw/rtl/tls_ram.sv
// ----------------------------------------------------------------------------
// tls_ram
// Generic single-write, single-read RAM with registered read (old data on
// a same-address write).
// ----------------------------------------------------------------------------
module tls_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

### hw/rtl/tls_front.sv
// ----------------------------------------------------------------------------
// tls_front
// Accepts request items, classifies them into commands and hands them to
// the command queue.
// ----------------------------------------------------------------------------
module tls_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tls_pkg::req_t req,
	output logic          busy,
	output logic          push,
	output tls_pkg::cmd_t cmd,
	input  logic          fifo_full
);

	logic          valid_q;
	tls_pkg::cmd_t cmd_q;
	tls_pkg::cmd_t cmd_new;
	logic          accept;

	assign push   = valid_q && !fifo_full;
	assign busy   = valid_q && fifo_full;
	assign accept = start && !busy;
	assign cmd    = cmd_q;

	always_comb begin
		cmd_new.id    = req.job_id;
		cmd_new.burst = req.burst;
		if (req.req_type == tls_pkg::REQ_TICK) begin
			cmd_new.op = tls_pkg::OP_TICK;
		end else if (req.job_class == tls_pkg::CLASS_HIGH) begin
			cmd_new.op = tls_pkg::OP_ARRIVE_HIGH;
		end else begin
			cmd_new.op = tls_pkg::OP_ARRIVE_LOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_new;
		end
	end

endmodule

### hw/rtl/tls_fifo.sv
// ----------------------------------------------------------------------------
// tls_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module tls_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tls_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output tls_pkg::cmd_t cmd
);

	tls_pkg::cmd_t mem_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign cmd   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

endmodule

### hw/rtl/tls_back.sv
// ----------------------------------------------------------------------------
// tls_back
// Executes commands: queue bookkeeping, per-job tables, time and slice
// counters. Each command passes an execute state, then a response state.
// ----------------------------------------------------------------------------
module tls_back #(
	parameter int MAX_JOBS = tls_pkg::MAX_JOBS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tls_pkg::SLICE_W-1:0] cfg_data,
	input  logic                        cmd_valid,
	input  tls_pkg::cmd_t               cmd,
	output logic                        cmd_pop,
	output logic                        rsp_valid,
	output tls_pkg::rsp_t               rsp
);

	localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam int SW = CW + 1;
	localparam int IW = tls_pkg::ID_W;
	localparam int BW = tls_pkg::BURST_W;
	localparam int TW = tls_pkg::TICK_W;
	localparam int LW = tls_pkg::SLICE_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_JOBS);

	localparam logic ST_EXEC = 1'b0;
	localparam logic ST_RESP = 1'b1;

	function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] head,
			input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(head) + SW'(off);
		if (sum >= SW'(MAX_JOBS)) begin
			sum = sum - SW'(MAX_JOBS);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] head);
		return (head == AW'(MAX_JOBS - 1)) ? '0 : head + AW'(1);
	endfunction

	logic state_q;

	logic [AW-1:0] hh_q, lh_q;
	logic [CW-1:0] hc_q, lc_q;
	logic [LW-1:0] slice_q;
	logic [TW-1:0] now_q;
	logic [LW-1:0] quantum_q;
	logic [IW-1:0] hid_q, lid_q;

	logic [BW-1:0] rem_q [tls_pkg::ID_SLOTS];
	logic [BW-1:0] bl_q  [tls_pkg::ID_SLOTS];
	logic [TW-1:0] arr_q [tls_pkg::ID_SLOTS];

	// execute-cycle results held for the response cycle
	logic          done_s2;
	logic [IW-1:0] done_id_s2;
	logic [TW-1:0] tat_s2;
	logic [BW-1:0] bl_s2;
	logic          hbyp_s2, lbyp_s2;
	logic [IW-1:0] hbyp_id_s2, lbyp_id_s2;

	logic          exec;
	logic          is_high, has_job;
	logic [IW-1:0] run;
	logic [BW-1:0] run_rem;
	logic [LW-1:0] slice_inc;

	logic [AW-1:0] n_hh, n_lh;
	logic [CW-1:0] n_hc, n_lc;
	logic [LW-1:0] n_slice;
	logic [TW-1:0] n_now;
	logic          h_we, l_we, tbl_we, rem_we, fin;
	logic [AW-1:0] h_waddr, l_waddr;
	logic [IW-1:0] l_wdata;
	logic [BW-1:0] rem_wdata;
	logic [TW-1:0] tat;

	logic [IW-1:0] h_rdata, l_rdata, hhead, lhead;

	assign exec    = (state_q == ST_EXEC) && cmd_valid;
	assign cmd_pop = exec;

	assign is_high   = (hc_q != '0);
	assign has_job   = is_high || (lc_q != '0);
	assign run       = is_high ? hid_q : lid_q;
	assign run_rem   = rem_q[run];
	assign slice_inc = (slice_q == '1) ? slice_q : slice_q + LW'(1);

	always_comb begin
		n_hh      = hh_q;
		n_lh      = lh_q;
		n_hc      = hc_q;
		n_lc      = lc_q;
		n_slice   = slice_q;
		n_now     = now_q;
		h_we      = 1'b0;
		l_we      = 1'b0;
		tbl_we    = 1'b0;
		rem_we    = 1'b0;
		fin       = 1'b0;
		h_waddr   = slot_add(hh_q, hc_q);
		l_waddr   = slot_add(lh_q, lc_q);
		l_wdata   = cmd.id;
		rem_wdata = '0;
		tat       = '0;
		case (cmd.op)
			tls_pkg::OP_ARRIVE_HIGH: begin
				if (hc_q != FULL_CNT) begin
					// preempts a running low job
					if (hc_q == '0) begin
						n_slice = '0;
					end
					tbl_we = 1'b1;
					h_we   = 1'b1;
					n_hc   = hc_q + CW'(1);
				end
			end
			tls_pkg::OP_ARRIVE_LOW: begin
				if (lc_q != FULL_CNT) begin
					tbl_we = 1'b1;
					l_we   = 1'b1;
					n_lc   = lc_q + CW'(1);
				end
			end
			tls_pkg::OP_TICK: begin
				n_now = (now_q == '1) ? now_q : now_q + TW'(1);
				if (has_job) begin
					rem_we  = 1'b1;
					n_slice = slice_inc;
					if (run_rem <= BW'(1)) begin
						fin     = 1'b1;
						tat     = n_now - arr_q[run];
						n_slice = '0;
						if (is_high) begin
							n_hh = slot_inc(hh_q);
							n_hc = hc_q - CW'(1);
						end else begin
							n_lh = slot_inc(lh_q);
							n_lc = lc_q - CW'(1);
						end
					end else begin
						rem_wdata = run_rem - BW'(1);
						// rotate behind the other low jobs
						if (!is_high && slice_inc >= quantum_q && lc_q > CW'(1)) begin
							l_we    = 1'b1;
							l_wdata = run;
							n_lh    = slot_inc(lh_q);
							n_slice = '0;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	tls_ram #(.WIDTH(IW), .DEPTH(MAX_JOBS), .AW(AW)) u_high_q (
		.clk   (clk),
		.we    (exec && h_we),
		.waddr (h_waddr),
		.wdata (cmd.id),
		.raddr (n_hh),
		.rdata (h_rdata)
	);

	tls_ram #(.WIDTH(IW), .DEPTH(MAX_JOBS), .AW(AW)) u_low_q (
		.clk   (clk),
		.we    (exec && l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (n_lh),
		.rdata (l_rdata)
	);

	// head slot written in the same cycle it is read: take the new id
	assign hhead = hbyp_s2 ? hbyp_id_s2 : h_rdata;
	assign lhead = lbyp_s2 ? lbyp_id_s2 : l_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_EXEC;
			hh_q      <= '0;
			lh_q      <= '0;
			hc_q      <= '0;
			lc_q      <= '0;
			slice_q   <= '0;
			now_q     <= '0;
			quantum_q <= tls_pkg::QUANTUM_RESET;
			done_s2   <= 1'b0;
			hbyp_s2   <= 1'b0;
			lbyp_s2   <= 1'b0;
		end else begin
			if (cfg_we) begin
				quantum_q <= cfg_data;
			end
			case (state_q)
				ST_EXEC: begin
					if (exec) begin
						hh_q    <= n_hh;
						lh_q    <= n_lh;
						hc_q    <= n_hc;
						lc_q    <= n_lc;
						slice_q <= n_slice;
						now_q   <= n_now;
						done_s2 <= fin;
						hbyp_s2 <= h_we && (h_waddr == n_hh);
						lbyp_s2 <= l_we && (l_waddr == n_lh);
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					state_q <= ST_EXEC;
				end
				default: begin
					state_q <= ST_EXEC;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			done_id_s2 <= run;
			tat_s2     <= tat;
			bl_s2      <= bl_q[run];
			hbyp_id_s2 <= cmd.id;
			lbyp_id_s2 <= l_wdata;
			if (tbl_we) begin
				rem_q[cmd.id] <= cmd.burst;
				bl_q[cmd.id]  <= cmd.burst;
				arr_q[cmd.id] <= now_q;
			end else if (rem_we) begin
				rem_q[run] <= rem_wdata;
			end
		end
		if (state_q == ST_RESP) begin
			hid_q <= hhead;
			lid_q <= lhead;
		end
	end

	always_comb begin
		rsp_valid         = (state_q == ST_RESP);
		rsp.running_valid = (hc_q != '0) || (lc_q != '0);
		if (hc_q != '0) begin
			rsp.running_id = hhead;
		end else if (lc_q != '0) begin
			rsp.running_id = lhead;
		end else begin
			rsp.running_id = '0;
		end
		rsp.done_valid = done_s2;
		rsp.done_id    = done_s2 ? done_id_s2 : '0;
		rsp.turnaround = done_s2 ? tat_s2 : '0;
		if (done_s2 && tat_s2 >= TW'(bl_s2)) begin
			rsp.waiting = tat_s2 - TW'(bl_s2);
		end else begin
			rsp.waiting = '0;
		end
	end

endmodule

### hw/rtl/two_level_tick_scheduler.sv
// ----------------------------------------------------------------------------
// two_level_tick_scheduler
// Two-level job scheduler: preemptive first-come high class over a
// round-robin low class, driven by arrival and tick items.
// ----------------------------------------------------------------------------
// Input: an item (req) is taken at a clock edge with start high and busy low.
// An arrival queues a job; a tick advances time and serves the running job.
// Output: every item gives one result, shown on rsp for a single cycle with
// rsp_valid high. The receiver cannot stall; results are never held back.
// An item passes the front register, command queue, execute and response.
// The back end alternates execute and response per command, around the
// registered read of the job queue memories, so it takes no new command
// before the previous response is shown. A two-entry command queue lets the
// front take items while the back works; busy rises only when both the queue
// and the front register are full. The user must write time_quantum through
// cfg_we/cfg_data only while idle; the block itself does not enforce this.
// Reset: queues empty, time and slice counters zero, quantum 4. The queue
// memories and per-job tables are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module two_level_tick_scheduler #(
	parameter int MAX_JOBS = tls_pkg::MAX_JOBS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  tls_pkg::req_t               req,
	input  logic                        cfg_we,
	input  logic [tls_pkg::SLICE_W-1:0] cfg_data,
	output logic                        rsp_valid,
	output tls_pkg::rsp_t               rsp
);

	logic          push;
	logic          fifo_full;
	logic          fifo_valid;
	logic          pop;
	tls_pkg::cmd_t front_cmd;
	tls_pkg::cmd_t back_cmd;

	tls_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.push      (push),
		.cmd       (front_cmd),
		.fifo_full (fifo_full)
	);

	tls_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.full     (fifo_full),
		.pop      (pop),
		.valid    (fifo_valid),
		.cmd      (back_cmd)
	);

	tls_back #(.MAX_JOBS(MAX_JOBS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd_valid (fifo_valid),
		.cmd       (back_cmd),
		.cmd_pop   (pop),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

### hw/rtl/tls_checker.sv
// ----------------------------------------------------------------------------
// tls_checker
// Port-level checks on the scheduler's result stream.
// ----------------------------------------------------------------------------
module tls_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input tls_pkg::rsp_t rsp
);

	// execute and response alternate, so results never come back to back
	a_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |=> !rsp_valid)
		else $error("results in consecutive cycles");

	a_idle_id: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.running_valid) |-> (rsp.running_id == '0))
		else $error("running id set with no running job");

	a_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.done_valid) |->
		(rsp.done_id == '0 && rsp.turnaround == '0 && rsp.waiting == '0))
		else $error("finish fields set with no finished job");

	a_wait_le: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.done_valid) |-> (rsp.waiting <= rsp.turnaround))
		else $error("waiting exceeds turnaround");

endmodule

bind two_level_tick_scheduler tls_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp       (rsp)
);

### sim/two_level_tick_scheduler_checker.sv
// ----------------------------------------------------------------------------
// two_level_tick_scheduler_checker
// Watches the request, config and response channels of the tick scheduler,
// keeps its own copy of the job queues and tables, predicts one response
// per accepted item and compares responses field by field in order.
// ----------------------------------------------------------------------------
module two_level_tick_scheduler_checker #(
	parameter int MAX_JOBS = tls_pkg::MAX_JOBS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  tls_pkg::req_t               req,
	input  logic                        cfg_we,
	input  logic [tls_pkg::SLICE_W-1:0] cfg_data,
	input  logic                        rsp_valid,
	input  tls_pkg::rsp_t               rsp,
	output int                          errors,
	output int                          pending,
	output int                          jobs_done
);

	import tls_pkg::*;

	localparam int SHOW_MAX = 40;

	// predicted scheduler state
	logic [ID_W-1:0]    hi_q [MAX_JOBS];
	logic [ID_W-1:0]    lo_q [MAX_JOBS];
	int                 hi_head, hi_cnt, lo_head, lo_cnt;
	logic [BURST_W-1:0] left_ticks [ID_SLOTS];
	logic [BURST_W-1:0] burst_of [ID_SLOTS];
	logic [TICK_W-1:0]  arrived_at [ID_SLOTS];
	logic [SLICE_W-1:0] slice;
	logic [TICK_W-1:0]  now;
	logic [SLICE_W-1:0] quantum;

	rsp_t rsp_due [$];

	task automatic note_mismatch(input string what, input logic [TICK_W-1:0] want,
			input logic [TICK_W-1:0] got);
		if (errors < SHOW_MAX)
			$display("[%0t] MISMATCH %s: expected %h, got %h", $time, what, want, got);
		errors++;
	endtask

	// one scheduler step: apply an arrival or a tick, return the response
	function automatic rsp_t advance_scheduler(input req_t it);
		rsp_t            r;
		logic            on_high;
		logic [ID_W-1:0] run;
		r = '0;
		if (it.req_type != REQ_TICK) begin
			if (it.job_class == CLASS_HIGH) begin
				if (hi_cnt < MAX_JOBS) begin
					if (hi_cnt == 0)
						slice = '0; // preempts a running low job
					left_ticks[it.job_id] = it.burst;
					burst_of[it.job_id]   = it.burst;
					arrived_at[it.job_id] = now;
					hi_q[(hi_head + hi_cnt) % MAX_JOBS] = it.job_id;
					hi_cnt++;
				end
			end else if (lo_cnt < MAX_JOBS) begin
				left_ticks[it.job_id] = it.burst;
				burst_of[it.job_id]   = it.burst;
				arrived_at[it.job_id] = now;
				lo_q[(lo_head + lo_cnt) % MAX_JOBS] = it.job_id;
				lo_cnt++;
			end
		end else begin
			if (now != '1)
				now++;
			if (hi_cnt != 0 || lo_cnt != 0) begin
				on_high = (hi_cnt != 0);
				run = on_high ? hi_q[hi_head] : lo_q[lo_head];
				if (slice != '1)
					slice++;
				if (left_ticks[run] <= 1) begin
					left_ticks[run] = '0;
					r.done_valid = 1'b1;
					r.done_id    = run;
					r.turnaround = now - arrived_at[run];
					r.waiting    = (r.turnaround >= burst_of[run]) ?
						r.turnaround - burst_of[run] : '0;
					if (on_high) begin
						hi_head = (hi_head + 1) % MAX_JOBS;
						hi_cnt--;
					end else begin
						lo_head = (lo_head + 1) % MAX_JOBS;
						lo_cnt--;
					end
					slice = '0;
				end else begin
					left_ticks[run]--;
					// round-robin rotation only when another low job waits
					if (!on_high && slice >= quantum && lo_cnt > 1) begin
						lo_q[(lo_head + lo_cnt) % MAX_JOBS] = run;
						lo_head = (lo_head + 1) % MAX_JOBS;
						slice = '0;
					end
				end
			end
		end
		if (hi_cnt != 0) begin
			r.running_valid = 1'b1;
			r.running_id    = hi_q[hi_head];
		end else if (lo_cnt != 0) begin
			r.running_valid = 1'b1;
			r.running_id    = lo_q[lo_head];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			hi_head   = 0;
			hi_cnt    = 0;
			lo_head   = 0;
			lo_cnt    = 0;
			slice     = '0;
			now       = '0;
			quantum   = QUANTUM_RESET;
			errors    = 0;
			jobs_done = 0;
			rsp_due.delete();
		end else begin
			if (rsp_valid) begin
				if (rsp_due.size() == 0) begin
					note_mismatch("response with no item outstanding", '0,
						TICK_W'(rsp.running_id));
				end else begin
					want = rsp_due.pop_front();
					if (rsp.running_valid !== want.running_valid)
						note_mismatch("running_valid", TICK_W'(want.running_valid),
							TICK_W'(rsp.running_valid));
					if (rsp.running_id !== want.running_id)
						note_mismatch("running_id", TICK_W'(want.running_id),
							TICK_W'(rsp.running_id));
					if (rsp.done_valid !== want.done_valid)
						note_mismatch("done_valid", TICK_W'(want.done_valid),
							TICK_W'(rsp.done_valid));
					if (rsp.done_id !== want.done_id)
						note_mismatch("done_id", TICK_W'(want.done_id),
							TICK_W'(rsp.done_id));
					if (rsp.turnaround !== want.turnaround)
						note_mismatch("turnaround", want.turnaround, rsp.turnaround);
					if (rsp.waiting !== want.waiting)
						note_mismatch("waiting", want.waiting, rsp.waiting);
					if (want.done_valid)
						jobs_done++;
				end
			end
			if (cfg_we)
				quantum = cfg_data;
			if (start && !busy)
				rsp_due.push_back(advance_scheduler(req));
		end
		pending = rsp_due.size();
	end

endmodule

### sim/tb_two_level_tick_scheduler.sv
// ----------------------------------------------------------------------------
// tb_two_level_tick_scheduler
// Stimulus and verdict for the two-level tick scheduler: a directed opening,
// random arrival/tick traffic under several quanta and idle patterns, and a
// short closing run at the reset quantum. Checking is in the checker.
// ----------------------------------------------------------------------------
module tb_two_level_tick_scheduler;

	import tls_pkg::*;

	localparam logic REQ_ARRIVE = 1'b0;
	localparam logic CLASS_LOW  = 1'b1;
	localparam int   QUIET_MAX  = 2000;
	localparam int   PHASES     = 6;
	localparam int   PHASE_ITEMS = 165;
	localparam int   TAIL_TICKS = 40;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	req_t               req;
	logic               cfg_we;
	logic [SLICE_W-1:0] cfg_data;
	logic               rsp_valid;
	rsp_t               rsp;

	int errors, pending, jobs_done;
	int items_sent, ticks_sent, quiet;

	two_level_tick_scheduler u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

	two_level_tick_scheduler_checker u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.rsp_valid(rsp_valid),
		.rsp      (rsp),
		.errors   (errors),
		.pending  (pending),
		.jobs_done(jobs_done)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ends the run if nothing moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || rsp_valid)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_MAX) begin
			$display("Timeout: no item accepted for %0d cycles", QUIET_MAX);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_item(input req_t it, input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		start = 1'b1;
		req   = it;
		do @(posedge clk); while (busy);
		@(negedge clk);
		items_sent++;
		if (it.req_type == REQ_TICK)
			ticks_sent++;
	endtask

	function automatic req_t make_req(input logic kind, input logic [ID_W-1:0] id,
			input logic cls, input logic [BURST_W-1:0] len);
		req_t it;
		it.req_type  = kind;
		it.job_id    = id;
		it.job_class = cls;
		it.burst     = len;
		return it;
	endfunction

	function automatic req_t random_tick();
		return make_req(REQ_TICK, ID_W'($urandom_range(15)), 1'($urandom_range(1)),
			BURST_W'($urandom_range(255)));
	endfunction

	function automatic logic [BURST_W-1:0] random_burst();
		int sel;
		sel = $urandom_range(59);
		if (sel == 0)
			return BURST_W'($urandom_range(255));
		if (sel == 1)
			return '0;
		return BURST_W'($urandom_range(1, 5));
	endfunction

	// wait until every predicted response has come back, then settle
	task automatic drain_responses();
		start = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_quantum(input logic [SLICE_W-1:0] value);
		drain_responses();
		cfg_we   = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_we   = 1'b0;
	endtask

	task automatic run_random_phase(input int count, input int idle_pct);
		int   n;
		int   k;
		logic cls;
		n = 0;
		while (n < count) begin
			if ($urandom_range(149) == 0) begin
				// flood one class past its capacity
				cls = 1'($urandom_range(1));
				for (k = 0; k < 18; k++)
					send_item(make_req(REQ_ARRIVE, ID_W'($urandom_range(15)), cls,
						BURST_W'($urandom_range(1, 3))), idle_pct);
				n += 18;
			end else if ($urandom_range(99) < 15) begin
				send_item(make_req(REQ_ARRIVE, ID_W'($urandom_range(15)),
					1'($urandom_range(1)), random_burst()), idle_pct);
				n++;
			end else begin
				send_item(random_tick(), idle_pct);
				n++;
			end
			if (n == count / 2 && $urandom_range(1) == 0)
				drain_responses();
		end
	endtask

	initial begin
		logic [SLICE_W-1:0] quanta [PHASES];
		int                 idles [PHASES];
		int                 p;
		quanta = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd3, 8'd8};
		idles  = '{0, 74, 0, 25, 74, 10};
		arst_n     = 1'b0;
		start      = 1'b0;
		req        = '0;
		cfg_we     = 1'b0;
		cfg_data   = '0;
		items_sent = 0;
		ticks_sent = 0;
		quiet      = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed opening at the reset quantum
		send_item(make_req(REQ_TICK, 4'hF, CLASS_LOW, 8'hFF), 0); // tick on empty server
		send_item(make_req(REQ_ARRIVE, 4'd0, CLASS_LOW, 8'd3), 0);
		send_item(make_req(REQ_ARRIVE, 4'hF, CLASS_LOW, 8'd0), 0); // zero burst
		send_item(make_req(REQ_TICK, 4'd0, CLASS_HIGH, 8'd0), 0);
		send_item(make_req(REQ_TICK, 4'd0, CLASS_HIGH, 8'd0), 0);
		send_item(make_req(REQ_ARRIVE, 4'd5, CLASS_HIGH, 8'd255), 0); // preemption
		send_item(make_req(REQ_TICK, 4'd0, CLASS_HIGH, 8'd0), 0);
		send_item(make_req(REQ_ARRIVE, 4'd10, CLASS_HIGH, 8'd1), 0);
		send_item(make_req(REQ_ARRIVE, 4'd5, CLASS_HIGH, 8'd2), 0);  // id reused
		send_item(make_req(REQ_ARRIVE, 4'd7, CLASS_LOW, 8'd9), 0);
		repeat (15)
			send_item(make_req(REQ_TICK, 4'd0, CLASS_HIGH, 8'd0), 0);

		for (p = 0; p < PHASES; p++) begin
			write_quantum(quanta[p]);
			run_random_phase(PHASE_ITEMS, idles[p]);
		end

		// back to the reset quantum with a high job over two low jobs
		write_quantum(8'd4);
		send_item(make_req(REQ_ARRIVE, 4'd3, CLASS_HIGH, 8'd6), 0);
		send_item(make_req(REQ_ARRIVE, 4'd9, CLASS_LOW, 8'd20), 0);
		send_item(make_req(REQ_ARRIVE, 4'd12, CLASS_LOW, 8'd7), 0);
		repeat (TAIL_TICKS)
			send_item(random_tick(), 0);

		start = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d items (%0d ticks); %0d jobs finished", items_sent, ticks_sent,
			jobs_done);
		$display("Quanta 4,1,255,0,2,3,8 with idle mixes, queue floods and id reuse");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### two_level_tick_scheduler.f
hw/rtl/tls_pkg.sv
hw/rtl/tls_ram.sv
hw/rtl/tls_front.sv
hw/rtl/tls_fifo.sv
hw/rtl/tls_back.sv
hw/rtl/two_level_tick_scheduler.sv
hw/rtl/tls_checker.sv
sim/two_level_tick_scheduler_checker.sv
sim/tb_two_level_tick_scheduler.sv
